### rtl/prd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prd_pkg
// shared types and constants of the planar run-coded row decoder
// ----------------------------------------------------------------------------
package prd_pkg;

  // code byte values
  localparam logic [7:0] CodeFillN     = 8'h00;
  localparam logic [7:0] CodeOne       = 8'h01;
  localparam logic [7:0] CodeFillMax   = 8'h07;
  localparam logic [7:0] CodeOlderMax  = 8'h0d;
  localparam logic [7:0] CodeCopyP2    = 8'h0e;
  localparam logic [7:0] CodeCopyP01   = 8'h0f;
  localparam logic [7:0] OlderBias     = 8'h06;
  localparam logic [7:0] CountSplit    = 8'h80;

  // command operations handed from front to back
  typedef enum logic [1:0] {
    OpFill  = 2'd0,
    OpOlder = 2'd1,
    OpCopy  = 2'd2
  } op_e;

  // one queued command
  typedef struct packed {
    op_e        op;
    logic [1:0] src;
    logic [7:0] count;
    logic [7:0] value;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic [23:0] left_pixels;
    logic [23:0] right_pixels;
    logic [5:0]  pair_index;
    logic [3:0]  palette_high;
    logic        row_last;
    logic        image_last;
  } result_t;

  // three plane bytes to eight 3-bit pixels
  function automatic logic [23:0] chunky(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    logic [23:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[21 - 3 * i +: 3] = {b2[7 - i], b1[7 - i], b0[7 - i]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/prd_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prd_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface prd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/prd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prd_front
// parses code bytes into fill, older-fill and copy commands
// ----------------------------------------------------------------------------
module prd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    byte_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output prd_pkg::cmd_t      cmd_o
);
  import prd_pkg::*;

  localparam logic [1:0] PhCode  = 2'd0;
  localparam logic [1:0] PhOper  = 2'd1;
  localparam logic [1:0] PhValue = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] code_q, code_d, count_q, count_d;
  logic       emit;
  cmd_t       cmd;

  assign in_ready_o = cmd_ready_i;

  // classify the byte against the phase
  always_comb begin
    phase_d   = phase_q;
    code_d    = code_q;
    count_d   = count_q;
    emit      = 1'b0;
    cmd.op    = OpFill;
    cmd.src   = 2'd0;
    cmd.count = 8'd1;
    cmd.value = byte_i;
    case (phase_q)
      PhCode: begin
        if (byte_i <= CodeFillMax || byte_i == CodeCopyP2 || byte_i == CodeCopyP01) begin
          code_d  = byte_i;
          phase_d = PhOper;
        end else if (byte_i <= CodeOlderMax) begin
          emit      = 1'b1;
          cmd.op    = OpOlder;
          cmd.count = byte_i - OlderBias;
        end else begin
          emit = 1'b1;
        end
      end
      PhOper: begin
        phase_d = PhCode;
        emit    = 1'b1;
        if (code_q == CodeFillN) begin
          if (byte_i < CountSplit) begin
            count_d = byte_i;
            phase_d = PhValue;
            emit    = 1'b0;
          end else begin
            cmd.op    = OpOlder;
            cmd.count = byte_i - CountSplit;
          end
        end else if (code_q == CodeOne) begin
          cmd.count = 8'd1;
        end else if (code_q <= CodeFillMax) begin
          cmd.count = code_q;
        end else if (code_q == CodeCopyP2) begin
          cmd.op    = OpCopy;
          cmd.src   = 2'd2;
          cmd.count = byte_i;
        end else begin
          cmd.op = OpCopy;
          if (byte_i < CountSplit) begin
            cmd.src   = 2'd0;
            cmd.count = byte_i;
          end else begin
            cmd.src   = 2'd1;
            cmd.count = byte_i - CountSplit;
          end
        end
      end
      default: begin
        phase_d   = PhCode;
        emit      = 1'b1;
        cmd.count = count_q;
      end
    endcase
  end

  assign cmd_valid_o = in_valid_i && emit;
  assign cmd_o       = cmd;

  // phase registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCode;
      code_q  <= '0;
      count_q <= '0;
    end else if (in_valid_i && cmd_ready_i) begin
      phase_q <= phase_d;
      code_q  <= code_d;
      count_q <= count_d;
    end
  end
endmodule
`default_nettype wire

### rtl/prd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prd_queue
// two-entry command queue between parser and executor
// ----------------------------------------------------------------------------
module prd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  prd_pkg::cmd_t      wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output prd_pkg::cmd_t      rd_data_o
);
  import prd_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### rtl/prd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prd_back
// runs commands on the row stores, rotates history and emits column pairs
// ----------------------------------------------------------------------------
module prd_back #(
  parameter int MaxColumns = 80
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  prd_pkg::cmd_t      cmd_i,
  input  wire logic [6:0]    row_width_columns_i,
  input  wire logic [9:0]    image_rows_i,
  input  wire logic [4:0]    palette_select_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output prd_pkg::result_t   out_o
);
  import prd_pkg::*;

  localparam int XW = $clog2(MaxColumns + 1);
  localparam int AW = $clog2(MaxColumns);

  // sequencer states
  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StOlder   = 4'd1;
  localparam logic [3:0] StRun     = 4'd2;
  localparam logic [3:0] StCopy    = 4'd3;
  localparam logic [3:0] StShift   = 4'd4;
  localparam logic [3:0] StShiftWr = 4'd5;
  localparam logic [3:0] StEmit    = 4'd6;
  localparam logic [3:0] StEmitWr  = 4'd7;
  localparam logic [3:0] StClear   = 4'd8;

  logic [3:0]    st_q;
  logic [1:0]    pl_q;
  logic [7:0]    x_q;
  logic [7:0]    left_q;
  cmd_t          cmd_q;
  logic [7:0]    val_q;
  logic [7:0]    col_q;
  logic [9:0]    row_q;
  logic          last_q;
  logic [AW-1:0] clr_q;
  logic          obusy_q;
  result_t       out_q;

  // registered read data of every plane
  logic [7:0] cur_a_q [3];
  logic [7:0] cur_b_q [3];
  logic [7:0] prv_a_q [3];
  logic [7:0] old_a_q [3];

  logic [XW-1:0] w;
  logic [9:0]    rows;
  logic [7:0]    np;
  logic [7:0]    x_inc, x_sat, col_inc;
  logic [AW-1:0] ra, rb;
  logic          x_in, xo_in, in_w, in_w1, pair_last;
  logic          run_we, emit_fire;
  logic [7:0]    run_wd;
  logic [7:0]    b0, b1, b2, c0, c1, c2;

  // effective width and row count
  always_comb begin
    w = (row_width_columns_i == 7'd0) ? XW'(1) :
        ({1'b0, row_width_columns_i} > 8'(MaxColumns)) ? XW'(MaxColumns) :
        XW'(row_width_columns_i);
    rows = (image_rows_i == 10'd0) ? 10'd1 : image_rows_i;
    np   = 8'((9'(w) + 9'd1) >> 1);
  end

  assign cmd_ready_o = st_q == StIdle;
  assign out_valid_o = obusy_q;
  assign out_o       = out_q;

  // column position stays at or past the width once it gets there
  assign x_inc     = x_q + 8'd1;
  assign x_sat     = (x_q == 8'hff) ? x_q : x_inc;
  assign col_inc   = col_q + 8'd1;
  assign x_in      = {1'b0, x_q} < 9'(w);
  assign xo_in     = {1'b0, x_q} + 9'd1 < 9'(w);
  assign in_w      = {1'b0, col_q} < 9'(w);
  assign in_w1     = {1'b0, col_q} + 9'd1 < 9'(w);
  assign pair_last = (col_q[7:1] + 7'd1) == np[6:0];

  // read addresses, data arrives in the next cycle
  always_comb begin
    case (st_q)
      StIdle, StOlder: ra = x_inc[AW-1:0];
      StRun, StCopy:   ra = x_q[AW-1:0];
      default:         ra = col_q[AW-1:0];
    endcase
  end
  assign rb = col_inc[AW-1:0];

  // run writes into the current plane
  assign run_we = x_in && ((st_q == StRun && left_q != 8'd0 && cmd_q.op != OpCopy) ||
                           st_q == StCopy);
  assign run_wd = (st_q == StCopy) ? cur_a_q[cmd_q.src] : val_q;

  assign emit_fire = (st_q == StEmitWr) && (!obusy_q || out_ready_i);

  // column pair bytes, zero past the width
  assign b0 = in_w ? cur_a_q[0] : 8'd0;
  assign b1 = in_w ? cur_a_q[1] : 8'd0;
  assign b2 = in_w ? cur_a_q[2] : 8'd0;
  assign c0 = in_w1 ? cur_b_q[0] : 8'd0;
  assign c1 = in_w1 ? cur_b_q[1] : 8'd0;
  assign c2 = in_w1 ? cur_b_q[2] : 8'd0;

  // per-plane row stores
  for (genvar p = 0; p < 3; p++) begin : g_plane
    logic [7:0] cur_q [MaxColumns];
    logic [7:0] prv_q [MaxColumns];
    logic [7:0] old_q [MaxColumns];

    always_ff @(posedge clk_i) begin
      if (st_q == StClear) begin
        cur_q[clr_q] <= 8'd0;
        prv_q[clr_q] <= 8'd0;
        old_q[clr_q] <= 8'd0;
      end else begin
        if (run_we && pl_q == 2'(p)) cur_q[x_q[AW-1:0]] <= run_wd;
        if (st_q == StShiftWr) begin
          prv_q[col_q[AW-1:0]] <= cur_a_q[p];
          old_q[col_q[AW-1:0]] <= prv_a_q[p];
        end
      end
      cur_a_q[p] <= cur_q[ra];
      cur_b_q[p] <= cur_q[rb];
      prv_a_q[p] <= prv_q[ra];
      old_a_q[p] <= old_q[ra];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StClear;
      clr_q   <= '0;
      pl_q    <= '0;
      x_q     <= '0;
      left_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      last_q  <= 1'b0;
      obusy_q <= 1'b0;
      cmd_q   <= '0;
      val_q   <= '0;
      out_q   <= '0;
    end else begin
      if (emit_fire) obusy_q <= 1'b1;
      else if (out_ready_i) obusy_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (cmd_valid_i) begin
            cmd_q  <= cmd_i;
            val_q  <= cmd_i.value;
            left_q <= cmd_i.count;
            st_q   <= (cmd_i.op == OpOlder) ? StOlder : StRun;
          end
        end
        StOlder: begin
          val_q <= xo_in ? old_a_q[pl_q] : 8'd0;
          st_q  <= StRun;
        end
        StRun: begin
          if (left_q != 8'd0) begin
            if (cmd_q.op == OpCopy) begin
              st_q <= StCopy;
            end else begin
              left_q <= left_q - 8'd1;
              x_q    <= x_sat;
            end
          end else if (x_in) begin
            st_q <= StIdle;
          end else begin
            x_q <= '0;
            if (pl_q != 2'd2) begin
              pl_q <= pl_q + 2'd1;
              st_q <= StIdle;
            end else begin
              pl_q   <= '0;
              col_q  <= '0;
              row_q  <= row_q + 10'd1;
              last_q <= row_q + 10'd1 >= rows;
              st_q   <= StShift;
            end
          end
        end
        StCopy: begin
          left_q <= left_q - 8'd1;
          x_q    <= x_sat;
          st_q   <= StRun;
        end
        StShift: begin
          st_q <= StShiftWr;
        end
        StShiftWr: begin
          if (!in_w1) begin
            col_q <= '0;
            st_q  <= StEmit;
          end else begin
            col_q <= col_inc;
            st_q  <= StShift;
          end
        end
        StEmit: begin
          st_q <= StEmitWr;
        end
        StEmitWr: begin
          if (emit_fire) begin
            out_q.left_pixels  <= chunky(b0, b1, b2);
            out_q.right_pixels <= chunky(c0, c1, c2);
            out_q.pair_index   <= col_q[6:1];
            out_q.palette_high <= (palette_select_i == 5'h1f) ? 4'd0 : palette_select_i[3:0];
            out_q.row_last     <= pair_last;
            out_q.image_last   <= last_q && pair_last;
            if (pair_last) begin
              if (last_q) begin
                row_q <= '0;
                clr_q <= '0;
                st_q  <= StClear;
              end else begin
                st_q <= StIdle;
              end
            end else begin
              col_q <= col_q + 8'd2;
              st_q  <= StEmit;
            end
          end
        end
        StClear: begin
          if (clr_q == AW'(MaxColumns - 1)) st_q <= StIdle;
          clr_q <= clr_q + AW'(1);
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/planar_rle_image_row_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_rle_image_row_decoder_unit
// three-plane run-coded row decoder with planar-to-chunky pair output
// ----------------------------------------------------------------------------
// command path: a code is parsed and queued, and the executor takes it when idle;
//   a fill runs in StRun (after StOlder for an older fill), a copy in StRun/StCopy
// throughput: one byte beat per cycle while the two-entry queue has room
// row end: history is shifted column by column, then pair beats are emitted
// image end and reset: a clearing pass over all MAX_COLUMNS entries of the stores
// reset is asynchronous active low and clears all control state
module planar_rle_image_row_decoder_unit #(
  parameter int MAX_COLUMNS = 80
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  prd_stream_if.sink   in_if,
  prd_stream_if.source out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [9:0]  cfg_data_i
);
  import prd_pkg::*;

  localparam logic [1:0] RegWidth   = 2'd0;
  localparam logic [1:0] RegRows    = 2'd1;
  localparam logic [1:0] RegPalette = 2'd2;

  logic [6:0] width_q;
  logic [9:0] rows_q;
  logic [4:0] pal_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 7'd80;
      rows_q  <= 10'd200;
      pal_q   <= 5'h1f;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegWidth:   width_q <= cfg_data_i[6:0];
        RegRows:    rows_q  <= cfg_data_i;
        RegPalette: pal_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t fq_cmd, qb_cmd;

  prd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .byte_i     (in_if.payload),
    .cmd_valid_o(fq_valid),
    .cmd_ready_i(fq_ready),
    .cmd_o      (fq_cmd)
  );

  prd_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid),
    .wr_ready_o(fq_ready),
    .wr_data_i (fq_cmd),
    .rd_valid_o(qb_valid),
    .rd_ready_i(qb_ready),
    .rd_data_o (qb_cmd)
  );

  prd_back #(.MaxColumns(MAX_COLUMNS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i        (qb_valid),
    .cmd_ready_o        (qb_ready),
    .cmd_i              (qb_cmd),
    .row_width_columns_i(width_q),
    .image_rows_i       (rows_q),
    .palette_select_i   (pal_q),
    .out_valid_o        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .out_o              (out_if.payload)
  );
endmodule
`default_nettype wire
